### rtl/core/bpb_pkg.sv
`timescale 1ns / 1ps

package bpb_pkg;

  localparam int MAX_PIXELS = 32;
  localparam int PIX_AW     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int WALK_W     = $clog2(MAX_PIXELS + 1);
  localparam int CFG_W      = 6;
  localparam int CNT_W      = (WALK_W > CFG_W) ? WALK_W : CFG_W;
  localparam int DIV_W      = 16;
  localparam int DIV_CW     = $clog2(DIV_W + 1);
  localparam logic [CFG_W-1:0] PIX_COUNT_RST = CFG_W'(24);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SET   = 2'd2,
    ACT_CLEAR = 2'd3
  } bpb_action_e;

  typedef struct packed {
    bpb_action_e action;
    logic [4:0]  pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  level;
  } bpb_item_t;

  typedef struct packed {
    logic              load;
    logic              wr_en;
    logic              rd_en;
    logic              scan;
    logic [PIX_AW-1:0] addr;
    logic              clr;
    logic              res_clear;
    logic              res_raw;
    logic              res_div;
    logic [1:0]        res_ch;
    logic              div_start;
    logic              div_scale;
    logic [1:0]        div_ch;
    logic              scale_load;
    logic              scale_clr;
    logic              code_load;
    logic              out_load;
  } bpb_cmd_t;

  typedef struct packed {
    bpb_action_e      action;
    logic             in_range;
    logic             code_zero;
    logic             same_code;
    logic             old_zero;
    logic [CNT_W-1:0] count;
    logic             div_done;
  } bpb_status_t;

  function automatic logic [7:0] sat8(input logic [16:0] v);
    sat8 = (v > 17'd255) ? 8'hFF : v[7:0];
  endfunction

endpackage

### rtl/core/bpb_divider.sv
`timescale 1ns / 1ps

module bpb_divider
  import bpb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [7:0]       divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [7:0]        rem_q, rem_d;
  logic [7:0]        dsr_q, dsr_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [8:0]        rem_sh;
  logic              fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    fits   = (rem_sh >= {1'b0, dsr_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_W);
      rem_d  = '0;
      dsr_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? 8'(rem_sh - {1'b0, dsr_q}) : rem_sh[7:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_q)
    else $error("divider did not go busy after start");

endmodule

### rtl/core/bpb_datapath.sv
`timescale 1ns / 1ps

module bpb_datapath
  import bpb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bpb_item_t        item_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  bpb_cmd_t         cmd_i,
  output bpb_status_t      status_o,
  output logic [23:0]      out_data_o,
  output logic             out_flag_o
);

  bpb_item_t              item_q;
  logic [CFG_W-1:0]       pix_count_q;
  logic [7:0]             code_q;
  logic [MAX_PIXELS-1:0]  valid_q, valid_d;
  logic [2:0][7:0]        mem_q [MAX_PIXELS];
  logic [2:0][7:0]        rdata_q;
  logic                   rvalid_q;
  logic [DIV_W-1:0]       scale_q;
  logic [2:0][7:0]        res_q;
  logic [23:0]            rout_q;
  logic                   rng_q;

  logic [CNT_W-1:0]       count;
  logic [7:0]             next_code;
  logic [7:0]             old_code;
  logic [DIV_W-1:0]       scale_num;
  logic [2:0][7:0]        pix;
  logic [2:0][7:0]        chan;
  logic [2:0][7:0]        wdata;
  logic [16:0]            factor;
  logic [PIX_AW-1:0]      addr;
  logic [DIV_W-1:0]       div_dividend;
  logic [7:0]             div_divisor;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quo;

  always_comb begin
    count = (CNT_W'(pix_count_q) > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                        : CNT_W'(pix_count_q);
    next_code = item_q.level + 8'd1;
    old_code  = code_q - 8'd1;
    scale_num = (item_q.level == 8'hFF) ? 16'hFFFF : ({next_code, 8'h00} - 16'd1);
    pix       = rvalid_q ? rdata_q : '0;
    chan      = {item_q.blue, item_q.green, item_q.red};
    addr      = cmd_i.scan ? cmd_i.addr : PIX_AW'(item_q.pixel_index);
    if (cmd_i.scan) begin
      factor = {1'b0, scale_q};
    end else if (code_q == 8'd0) begin
      factor = 17'd256;
    end else begin
      factor = {9'd0, code_q};
    end
    for (int k = 0; k < 3; k++) begin
      logic [24:0] prod;
      prod     = {17'd0, (cmd_i.scan ? pix[k] : chan[k])} * {8'd0, factor};
      wdata[k] = sat8(prod[24:8]);
    end
    div_dividend = cmd_i.div_scale ? scale_num : {pix[cmd_i.div_ch], 8'h00};
    div_divisor  = cmd_i.div_scale ? old_code : code_q;

    valid_d = valid_q;
    if (cmd_i.clr) begin
      for (int i = 0; i < MAX_PIXELS; i++) begin
        if (CNT_W'(i) < count) begin
          valid_d[i] = 1'b0;
        end
      end
    end
    if (cmd_i.wr_en) begin
      valid_d[addr] = 1'b1;
    end
  end

  bpb_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_count_q <= PIX_COUNT_RST;
      code_q      <= 8'd0;
      valid_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        pix_count_q <= cfg_wdata_i;
      end
      if (cmd_i.code_load) begin
        code_q <= next_code;
      end
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.wr_en) begin
      mem_q[addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q  <= mem_q[addr];
      rvalid_q <= valid_q[addr];
    end
    if (cmd_i.scale_load) begin
      scale_q <= cmd_i.scale_clr ? '0 : div_quo;
    end
    if (cmd_i.res_clear) begin
      res_q <= '0;
    end else if (cmd_i.res_raw) begin
      res_q <= pix;
    end else if (cmd_i.res_div) begin
      res_q[cmd_i.res_ch] <= sat8({1'b0, div_quo});
    end
    if (cmd_i.out_load) begin
      rout_q <= res_q;
      rng_q  <= status_o.in_range;
    end
  end

  assign status_o.action    = item_q.action;
  assign status_o.in_range  = (CNT_W'(item_q.pixel_index) < count);
  assign status_o.code_zero = (code_q == 8'd0);
  assign status_o.same_code = (next_code == code_q);
  assign status_o.old_zero  = (old_code == 8'd0);
  assign status_o.count     = count;
  assign status_o.div_done  = div_done;

  assign out_data_o = rout_q;
  assign out_flag_o = rng_q;

endmodule

### rtl/core/bpb_controller.sv
`timescale 1ns / 1ps

module bpb_controller
  import bpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  input  bpb_status_t status_i,
  output bpb_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_WAIT,
    S_RD_DIV,
    S_RD_OUT,
    S_SC_DIV,
    S_RS_RD,
    S_RS_WR
  } state_e;

  state_e            state_q, state_d;
  logic [WALK_W-1:0] walk_q, walk_d;
  logic [1:0]        ch_q, ch_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.addr  = walk_q[PIX_AW-1:0];
    state_d     = state_q;
    walk_d      = walk_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q & ~m_tready_i;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        case (status_i.action)
          ACT_WRITE: begin
            cmd_o.wr_en = status_i.in_range;
          end
          ACT_READ: begin
            if (status_i.in_range) begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_RD_WAIT;
            end else begin
              cmd_o.res_clear = 1'b1;
              state_d         = S_RD_OUT;
            end
          end
          ACT_SET: begin
            if (!status_i.same_code) begin
              if (status_i.old_zero) begin
                cmd_o.scale_load = 1'b1;
                cmd_o.scale_clr  = 1'b1;
                walk_d           = '0;
                state_d          = S_RS_RD;
              end else begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_scale = 1'b1;
                state_d         = S_SC_DIV;
              end
            end
          end
          ACT_CLEAR: begin
            cmd_o.clr = 1'b1;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RD_WAIT: begin
        if (status_i.code_zero) begin
          cmd_o.res_raw = 1'b1;
          state_d       = S_RD_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_ch    = 2'd0;
          ch_d            = 2'd0;
          state_d         = S_RD_DIV;
        end
      end
      S_RD_DIV: begin
        if (status_i.div_done) begin
          cmd_o.res_div = 1'b1;
          cmd_o.res_ch  = ch_q;
          if (ch_q == 2'd2) begin
            state_d = S_RD_OUT;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_ch    = ch_q + 2'd1;
            ch_d            = ch_q + 2'd1;
          end
        end
      end
      S_RD_OUT: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SC_DIV: begin
        if (status_i.div_done) begin
          cmd_o.scale_load = 1'b1;
          walk_d           = '0;
          state_d          = S_RS_RD;
        end
      end
      S_RS_RD: begin
        if (CNT_W'(walk_q) < status_i.count) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.scan  = 1'b1;
          state_d     = S_RS_WR;
        end else begin
          cmd_o.code_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_RS_WR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.scan  = 1'b1;
        walk_d      = walk_q + WALK_W'(1);
        state_d     = S_RS_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walk_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_tready_i))
    else $error("output register overwritten while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_en && cmd_o.scan) |-> (CNT_W'(walk_q) < status_i.count))
    else $error("rescale write beyond pixels in use");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_OUT) |-> (status_i.action == ACT_READ))
    else $error("result produced for a non-read transaction");

endmodule

### rtl/core/brightness_scaled_pixel_buffer.sv
`timescale 1ns / 1ps

// RGB pixel buffer with a global brightness code.
// Input stream: s_tuser_i carries the action (write, read, set brightness,
// clear); s_tdata_i carries the pixel index, the three channels and the level.
// Only reads produce a transaction on the output stream: m_tdata_o holds the
// unscaled channels, m_tuser_o flags whether the index was in use.
// cfg_we_i/cfg_wdata_i set the number of pixels in use; write only while idle.
// One transaction is processed at a time; s_tready_o is high only when idle.
// Write and clear complete in the dispatch state. A read at full scale returns
// the raw channels; otherwise the shared 16-step divider runs once per channel.
// Set brightness runs the scale division (skipped when the old level was off,
// and nothing is done when the level is unchanged), then a read-modify-write
// sweep of the pixel memory over every pixel in use.
// The output register holds a finished result while the sink stalls; the next
// transaction is still accepted, and a later read waits for the register.
// Reset: brightness is full scale, 24 pixels in use, every pixel reads zero
// (per-pixel valid bits are cleared, so no clearing sweep is needed).

module brightness_scaled_pixel_buffer
  import bpb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [39:0]      s_tdata_i,   // pixel_index, red, green, blue, level, zero pad
  input  logic [1:0]       s_tuser_i,   // action
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [23:0]      m_tdata_o,   // red_out, green_out, blue_out
  output logic [0:0]       m_tuser_o,   // in_range
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  bpb_item_t   item;
  bpb_cmd_t    cmd;
  bpb_status_t status;
  logic        out_flag;

  always_comb begin
    item.action      = bpb_action_e'(s_tuser_i);
    item.pixel_index = s_tdata_i[4:0];
    item.red         = s_tdata_i[12:5];
    item.green       = s_tdata_i[20:13];
    item.blue        = s_tdata_i[28:21];
    item.level       = s_tdata_i[36:29];
  end

  bpb_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bpb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_tdata_o),
    .out_flag_o  (out_flag)
  );

  assign m_tuser_o = out_flag;

endmodule

### sim/brightness_scaled_pixel_buffer_tb.sv
`timescale 1ns / 1ps

module brightness_scaled_pixel_buffer_tb
  import bpb_pkg::*;
;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int IDLE_PCT      = 22;
  localparam int MAX_PRINTS    = 40;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_range;
  } pixel_read_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             s_tvalid_i  = 1'b0;
  logic             s_tready_o;
  logic [39:0]      s_tdata_i   = '0;  // pixel_index, red, green, blue, level, zero pad
  logic [1:0]       s_tuser_i   = '0;  // action
  logic             m_tvalid_o;
  logic             m_tready_i  = 1'b0;
  logic [23:0]      m_tdata_o;         // red_out, green_out, blue_out
  logic [0:0]       m_tuser_o;         // in_range
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  brightness_scaled_pixel_buffer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // shadow copy of the pixel buffer
  logic [7:0]  shadow_pix [MAX_PIXELS][3];
  logic [7:0]  shadow_code;
  int unsigned shadow_in_use;

  bpb_item_t   pending_ops[$];
  pixel_read_t expected_reads[$];
  bpb_item_t   cur_op;
  bit          steady = 1'b0;

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned n_writes = 0, n_reads = 0, n_sets = 0, n_clears = 0;
  int unsigned n_cfg = 0, n_checked = 0;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [7:0] sat_byte(input int unsigned v);
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [7:0] unscale_byte(input logic [7:0] p);
    if (shadow_code == 8'd0)
      return p;
    return sat_byte((int'(p) << 8) / int'(shadow_code));
  endfunction

  function automatic void apply_pixel_action(input bpb_item_t op);
    logic [7:0]  ch [3];
    logic [7:0]  nxt_code;
    logic [7:0]  old_code;
    int unsigned scale;
    int unsigned v;
    pixel_read_t rd;
    ch[0] = op.red;
    ch[1] = op.green;
    ch[2] = op.blue;
    case (op.action)
      ACT_WRITE: begin
        n_writes++;
        if (op.pixel_index < shadow_in_use) begin
          for (int k = 0; k < 3; k++) begin
            v = ch[k];
            if (shadow_code != 8'd0)
              v = (v * shadow_code) >> 8;
            shadow_pix[op.pixel_index][k] = v[7:0];
          end
        end
      end
      ACT_READ: begin
        n_reads++;
        if (op.pixel_index < shadow_in_use) begin
          rd.red      = unscale_byte(shadow_pix[op.pixel_index][0]);
          rd.green    = unscale_byte(shadow_pix[op.pixel_index][1]);
          rd.blue     = unscale_byte(shadow_pix[op.pixel_index][2]);
          rd.in_range = 1'b1;
        end else begin
          rd = '{8'd0, 8'd0, 8'd0, 1'b0};
        end
        expected_reads.push_back(rd);
      end
      ACT_SET: begin
        n_sets++;
        nxt_code = op.level + 8'd1;
        if (nxt_code != shadow_code) begin
          old_code = shadow_code - 8'd1;
          if (old_code == 8'd0)
            scale = 0;
          else if (op.level == 8'd255)
            scale = 65535 / old_code;
          else
            scale = ((int'(nxt_code) << 8) - 1) / old_code;
          scale &= 32'hFFFF;
          for (int i = 0; i < shadow_in_use; i++)
            for (int k = 0; k < 3; k++)
              shadow_pix[i][k] = sat_byte((shadow_pix[i][k] * scale) >> 8);
          shadow_code = nxt_code;
        end
      end
      default: begin
        n_clears++;
        for (int i = 0; i < shadow_in_use; i++)
          for (int k = 0; k < 3; k++)
            shadow_pix[i][k] = 8'd0;
      end
    endcase
  endfunction

  // driver: one transaction at a time from pending_ops
  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit busy;
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else begin
      busy = s_tvalid_i;
      if (s_tvalid_i && s_tready_o) begin
        apply_pixel_action(cur_op);
        busy = 1'b0;
      end
      if (!busy && pending_ops.size() > 0 &&
          (steady || $urandom_range(99) >= IDLE_PCT)) begin
        cur_op = pending_ops.pop_front();
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= {3'b000, cur_op.level, cur_op.blue, cur_op.green, cur_op.red,
                       cur_op.pixel_index};
        s_tuser_i  <= cur_op.action;
      end else if (!busy) begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor: compare each read result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_read_t want;
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready_i) begin
        if (expected_reads.size() == 0) begin
          report_mismatch($sformatf("unexpected read result %h/%b", m_tdata_o, m_tuser_o));
        end else begin
          want = expected_reads.pop_front();
          n_checked++;
          if (m_tdata_o[7:0] !== want.red)
            report_mismatch($sformatf("red_out %h, want %h", m_tdata_o[7:0], want.red));
          if (m_tdata_o[15:8] !== want.green)
            report_mismatch($sformatf("green_out %h, want %h", m_tdata_o[15:8], want.green));
          if (m_tdata_o[23:16] !== want.blue)
            report_mismatch($sformatf("blue_out %h, want %h", m_tdata_o[23:16], want.blue));
          if (m_tuser_o[0] !== want.in_range)
            report_mismatch($sformatf("in_range %b, want %b", m_tuser_o[0], want.in_range));
        end
      end
      m_tready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads outstanding", cycle_count,
               expected_reads.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic bpb_item_t pixel_op(input bpb_action_e act, input int idx,
                                         input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] lvl);
    bpb_item_t op;
    op.action      = act;
    op.pixel_index = idx[4:0];
    op.red         = r;
    op.green       = g;
    op.blue        = b;
    op.level       = lvl;
    return op;
  endfunction

  function automatic logic [7:0] random_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)
      return 8'h00;
    if (pick < 16)
      return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic bpb_item_t random_pixel_op(input int unsigned in_use);
    bpb_item_t   op;
    int unsigned pick;
    pick = $urandom_range(99);
    op.action = (pick < 38) ? ACT_WRITE :
                (pick < 80) ? ACT_READ  :
                (pick < 97) ? ACT_SET   : ACT_CLEAR;
    if (in_use > 0 && $urandom_range(99) < 85)
      op.pixel_index = 5'($urandom_range(in_use - 1));
    else
      op.pixel_index = 5'($urandom_range(31));
    op.red   = random_byte();
    op.green = random_byte();
    op.blue  = random_byte();
    op.level = random_byte();
    return op;
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_ops.size() != 0 || s_tvalid_i || expected_reads.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_pixel_count(input logic [CFG_W-1:0] cnt);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt;
    shadow_in_use = (cnt > MAX_PIXELS) ? MAX_PIXELS : cnt;
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] counts [8];
    int               phase_items;
    for (int i = 0; i < MAX_PIXELS; i++)
      for (int k = 0; k < 3; k++)
        shadow_pix[i][k] = 8'd0;
    shadow_code   = 8'd0;
    shadow_in_use = PIX_COUNT_RST;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: raw full scale, range edges, same code, off, level 255, clear
    @(negedge clk_i);
    pending_ops.push_back(pixel_op(ACT_WRITE, 0,  8'hFF, 8'hFF, 8'hFF, 8'h00));
    pending_ops.push_back(pixel_op(ACT_WRITE, 23, 8'h00, 8'h80, 8'h01, 8'hFF));
    pending_ops.push_back(pixel_op(ACT_WRITE, 24, 8'h12, 8'h34, 8'h56, 8'h00));
    pending_ops.push_back(pixel_op(ACT_READ,  0,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_READ,  23, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pending_ops.push_back(pixel_op(ACT_READ,  24, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_READ,  31, 8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_SET,   0,  8'h00, 8'h00, 8'h00, 8'hFF));
    pending_ops.push_back(pixel_op(ACT_SET,   0,  8'h00, 8'h00, 8'h00, 8'd127));
    pending_ops.push_back(pixel_op(ACT_READ,  0,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_WRITE, 1,  8'hFF, 8'h7F, 8'h01, 8'h00));
    pending_ops.push_back(pixel_op(ACT_READ,  1,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_SET,   0,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_READ,  0,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_WRITE, 2,  8'hFF, 8'hFF, 8'hFF, 8'h00));
    pending_ops.push_back(pixel_op(ACT_SET,   0,  8'h00, 8'h00, 8'h00, 8'd200));
    pending_ops.push_back(pixel_op(ACT_READ,  1,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_WRITE, 5,  8'hFF, 8'h80, 8'h33, 8'h00));
    pending_ops.push_back(pixel_op(ACT_SET,   0,  8'h00, 8'h00, 8'h00, 8'hFF));
    pending_ops.push_back(pixel_op(ACT_READ,  5,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_WRITE, 23, 8'hAA, 8'h55, 8'hC3, 8'h00));
    pending_ops.push_back(pixel_op(ACT_CLEAR, 0,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_READ,  5,  8'h00, 8'h00, 8'h00, 8'h00));
    pending_ops.push_back(pixel_op(ACT_READ,  23, 8'h00, 8'h00, 8'h00, 8'h00));
    wait_idle();

    // pixel-count sweep: none, above max, max, one, random below max, just past max, random, reset value
    counts = '{6'd0, 6'd63, 6'd32, 6'd1, 6'($urandom_range(2, 31)), 6'd33,
               6'($urandom_range(63)), 6'd24};
    for (int p = 0; p < 8; p++) begin
      set_pixel_count(counts[p]);
      steady = (p == 2);
      phase_items = (p == 0) ? 60 : 250;
      @(negedge clk_i);
      for (int n = 0; n < phase_items; n++)
        pending_ops.push_back(random_pixel_op(shadow_in_use));
      wait_idle();
    end
    steady = 1'b0;

    $display("ran %0d writes, %0d reads (%0d results checked), %0d brightness sets,",
             n_writes, n_reads, n_checked, n_sets);
    $display("  %0d clears across %0d pixel-count settings, %0d mismatches",
             n_clears, n_cfg, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
